>>> sv/phc_pkg.sv
// ----------------------------------------------------------------------------
// Placement swap cost package
// Shared sizes, memory geometry and state encoding of the HPWL cost engine.
// ----------------------------------------------------------------------------
package phc_pkg;

  localparam int MaxNets   = 1024;
  localparam int MaxPins   = 16;
  localparam int MaxCells  = 1024;
  localparam int GridSide  = 64;

  localparam int NetW   = 10;
  localparam int PinW   = 4;
  localparam int CellW  = 10;
  localparam int CoordW = 6;
  localparam int SiteW  = 12;
  localparam int CostW  = 17;

  localparam int SiteDepth = GridSide * GridSide;
  localparam int PinDepth  = MaxNets * MaxPins;

  typedef enum logic [1:0] {
    CMD_LOAD_PIN = 2'd0,
    CMD_PLACE    = 2'd1,
    CMD_SWAP     = 2'd2,
    CMD_TOTAL    = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SW_A,
    ST_SW_B,
    ST_SW_C,
    ST_NET_RD,
    ST_NET_CNT,
    ST_PIN_RD,
    ST_PIN_POS,
    ST_PIN_ACC,
    ST_NET_END,
    ST_WR1,
    ST_WR2,
    ST_RESULT
  } state_t;

endpackage

>>> sv/phc_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module phc_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/placement_swap_hpwl_cost.sv
// ----------------------------------------------------------------------------
// Placement swap HPWL cost engine
// Keeps grid, cell positions and netlist in RAMs and sums net wirelength.
// ----------------------------------------------------------------------------
// After reset the block clears the site grid and the net pin counts, during
// which no word is accepted. Pin loads and placements complete in the cycle
// they are accepted. A swap or a total request walks nets
// 0..min(net_count, MaxNets)-1 one at a time through the pin and position RAMs,
// then waits for the previous cost word to be taken. Swap before and after
// costs are gathered in the same walk, the after positions being substituted
// for the two swapped cells.
module placement_swap_hpwl_cost
  import phc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // net_index, pin_index, cell_id, x_a, y_a, x_b, y_b, zero fill
  input  logic [55:0] s_tdata,
  // cmd
  input  logic [1:0]  s_tuser,
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  // cost_before, cost_after, total_cost, zero fill
  output logic [55:0] m_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data
);

  state_t state, state_next;

  logic [6:0]  grid_columns, grid_rows;
  logic [10:0] net_count;

  logic [1:0]        cmd;
  logic [CoordW-1:0] xa, ya, xb, yb;
  logic [10:0]       ca, cb;
  logic [11:0]       clr;
  logic [10:0]       n;
  logic [4:0]        p, cnt;
  logic [CellW-1:0]  c;
  logic              hit, seen;
  logic [6:0]        min_xb, min_yb, min_xa, min_ya;
  logic [5:0]        max_xb, max_yb, max_xa, max_ya;
  logic [CostW-1:0]  sum_b, sum_a;

  logic [NetW-1:0]   in_net;
  logic [PinW-1:0]   in_pin;
  logic [10:0]       in_cell;
  logic [CoordW-1:0] in_xa, in_ya;
  logic              accept;
  logic [10:0]       lim;

  logic              site_we;
  logic [SiteW-1:0]  site_waddr, site_raddr;
  logic [10:0]       site_wdata, site_rdata;
  logic              cnt_we;
  logic [NetW-1:0]   cnt_waddr;
  logic [4:0]        cnt_wdata, cnt_rdata;
  logic              pin_we;
  logic [CellW-1:0]  pin_rdata;
  logic              pos_we;
  logic [CellW-1:0]  pos_waddr;
  logic [11:0]       pos_wdata, pos_rdata;

  logic [5:0] px_b, py_b, px_a, py_a;
  logic       touch;
  logic [7:0] hpwl_b, hpwl_a;

  assign in_net  = s_tdata[9:0];
  assign in_pin  = s_tdata[13:10];
  assign in_cell = s_tdata[24:14];
  assign in_xa   = s_tdata[30:25];
  assign in_ya   = s_tdata[36:31];
  assign accept  = s_tvalid && s_tready;
  assign lim     = (net_count > 11'(MaxNets)) ? 11'(MaxNets) : net_count;

  phc_ram #(.Width(11), .Depth(SiteDepth)) u_site (
    .clk(clk), .we(site_we), .waddr(site_waddr), .wdata(site_wdata),
    .raddr(site_raddr), .rdata(site_rdata)
  );

  phc_ram #(.Width(5), .Depth(MaxNets)) u_cnt (
    .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
    .raddr(n[NetW-1:0]), .rdata(cnt_rdata)
  );

  phc_ram #(.Width(CellW), .Depth(PinDepth)) u_pin (
    .clk(clk), .we(pin_we), .waddr({in_net, in_pin}), .wdata(in_cell[CellW-1:0]),
    .raddr({n[NetW-1:0], p[PinW-1:0]}), .rdata(pin_rdata)
  );

  phc_ram #(.Width(12), .Depth(MaxCells)) u_pos (
    .clk(clk), .we(pos_we), .waddr(pos_waddr), .wdata(pos_wdata),
    .raddr(pin_rdata), .rdata(pos_rdata)
  );

  assign px_b  = pos_rdata[5:0];
  assign py_b  = pos_rdata[11:6];
  assign touch = (!ca[10] && c == ca[CellW-1:0]) || (!cb[10] && c == cb[CellW-1:0]);

  always_comb begin
    if (!cb[10] && c == cb[CellW-1:0]) begin
      px_a = xa;
      py_a = ya;
    end else if (!ca[10] && c == ca[CellW-1:0]) begin
      px_a = xb;
      py_a = yb;
    end else begin
      px_a = px_b;
      py_a = py_b;
    end
  end

  assign hpwl_b = ({2'b0, max_xb} - {1'b0, min_xb}) + ({2'b0, max_yb} - {1'b0, min_yb});
  assign hpwl_a = ({2'b0, max_xa} - {1'b0, min_xa}) + ({2'b0, max_ya} - {1'b0, min_ya});

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:   if (clr == 12'(SiteDepth - 1)) state_next = ST_IDLE;
      ST_IDLE: begin
        if (accept && s_tuser == CMD_SWAP) state_next = ST_SW_A;
        else if (accept && s_tuser == CMD_TOTAL) state_next = ST_NET_RD;
      end
      ST_SW_A:    state_next = ST_SW_B;
      ST_SW_B:    state_next = ST_SW_C;
      ST_SW_C:    state_next = ST_NET_RD;
      ST_NET_RD: begin
        if (n >= lim) state_next = (cmd == CMD_SWAP) ? ST_WR1 : ST_RESULT;
        else state_next = ST_NET_CNT;
      end
      ST_NET_CNT: state_next = (cnt_rdata == 5'd0) ? ST_NET_RD : ST_PIN_RD;
      ST_PIN_RD:  state_next = ST_PIN_POS;
      ST_PIN_POS: state_next = ST_PIN_ACC;
      ST_PIN_ACC: state_next = (p + 5'd1 == cnt) ? ST_NET_END : ST_PIN_RD;
      ST_NET_END: state_next = ST_NET_RD;
      ST_WR1:     state_next = ST_WR2;
      ST_WR2:     state_next = ST_RESULT;
      ST_RESULT:  if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default:    state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    s_tready   = (state == ST_IDLE);
    site_we    = 1'b0;
    site_waddr = {in_ya, in_xa};
    site_wdata = in_cell[10] ? 11'h7FF : in_cell;
    site_raddr = {ya, xa};
    cnt_we     = 1'b0;
    cnt_waddr  = in_net;
    cnt_wdata  = {1'b0, in_pin} + 5'd1;
    pin_we     = 1'b0;
    pos_we     = 1'b0;
    pos_waddr  = in_cell[CellW-1:0];
    pos_wdata  = {in_ya, in_xa};
    case (state)
      ST_CLEAR: begin
        site_we    = 1'b1;
        site_waddr = clr;
        site_wdata = 11'h7FF;
        cnt_we     = (clr < 12'(MaxNets));
        cnt_waddr  = clr[NetW-1:0];
        cnt_wdata  = 5'd0;
      end
      ST_IDLE: begin
        if (accept && s_tuser == CMD_LOAD_PIN && !in_cell[10]) begin
          pin_we = 1'b1;
          cnt_we = s_tlast;
        end
        if (accept && s_tuser == CMD_PLACE) begin
          site_we = 1'b1;
          pos_we  = !in_cell[10];
        end
      end
      ST_SW_B: site_raddr = {yb, xb};
      ST_WR1: begin
        site_we    = 1'b1;
        site_waddr = {ya, xa};
        site_wdata = cb;
        pos_we     = !ca[10];
        pos_waddr  = ca[CellW-1:0];
        pos_wdata  = {yb, xb};
      end
      ST_WR2: begin
        site_we    = 1'b1;
        site_waddr = {yb, xb};
        site_wdata = ca;
        pos_we     = !cb[10];
        pos_waddr  = cb[CellW-1:0];
        pos_wdata  = {ya, xa};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr          <= '0;
      m_tvalid     <= 1'b0;
      grid_columns <= 7'd64;
      grid_rows    <= 7'd64;
      net_count    <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          2'd0:    grid_columns <= cfg_data[6:0];
          2'd1:    grid_rows    <= cfg_data[6:0];
          2'd2:    net_count    <= cfg_data;
          default: begin
          end
        endcase
      end
      if (state == ST_CLEAR) clr <= clr + 12'd1;
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (state == ST_RESULT && (!m_tvalid || m_tready)) m_tvalid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        cmd   <= s_tuser;
        xa    <= in_xa;
        ya    <= in_ya;
        xb    <= s_tdata[42:37];
        yb    <= s_tdata[48:43];
        ca    <= 11'h7FF;
        cb    <= 11'h7FF;
        n     <= '0;
        sum_b <= '0;
        sum_a <= '0;
      end
      ST_SW_B: ca <= site_rdata;
      ST_SW_C: cb <= site_rdata;
      ST_NET_CNT: begin
        cnt    <= cnt_rdata;
        p      <= '0;
        hit    <= 1'b0;
        seen   <= 1'b0;
        min_xb <= grid_columns;
        min_xa <= grid_columns;
        min_yb <= grid_rows;
        min_ya <= grid_rows;
        max_xb <= '0;
        max_yb <= '0;
        max_xa <= '0;
        max_ya <= '0;
        if (cnt_rdata == 5'd0) n <= n + 11'd1;
      end
      ST_PIN_POS: c <= pin_rdata;
      ST_PIN_ACC: begin
        if ({1'b0, px_b} < min_xb) min_xb <= {1'b0, px_b};
        if ({1'b0, py_b} < min_yb) min_yb <= {1'b0, py_b};
        if ({1'b0, px_a} < min_xa) min_xa <= {1'b0, px_a};
        if ({1'b0, py_a} < min_ya) min_ya <= {1'b0, py_a};
        if (!seen || px_b > max_xb) max_xb <= px_b;
        if (!seen || py_b > max_yb) max_yb <= py_b;
        if (!seen || px_a > max_xa) max_xa <= px_a;
        if (!seen || py_a > max_ya) max_ya <= py_a;
        seen <= 1'b1;
        if (touch) hit <= 1'b1;
        p <= p + 5'd1;
      end
      ST_NET_END: begin
        if (cmd == CMD_TOTAL || hit) sum_b <= sum_b + CostW'(hpwl_b);
        if (cmd == CMD_SWAP && hit) sum_a <= sum_a + CostW'(hpwl_a);
        n <= n + 11'd1;
      end
      ST_RESULT: begin
        if (!m_tvalid || m_tready) begin
          if (cmd == CMD_SWAP) m_tdata <= {5'd0, {CostW{1'b0}}, sum_a, sum_b};
          else m_tdata <= {5'd0, sum_b, {CostW{1'b0}}, {CostW{1'b0}}};
        end
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  a_no_out_in_clear: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> !m_tvalid) else $error("result during clear");
  a_pin_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_PIN_RD |-> p < cnt) else $error("pin index past net size");
  a_net_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_NET_CNT |-> n < lim) else $error("net index past net count");
  a_result_loads: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RESULT && !m_tvalid) |=> m_tvalid) else $error("result lost");
`endif

endmodule
